/* sv/twcs_pkg.sv */
// ----------------------------------------------------------------------------
// twcs_pkg
// Shared types and constants of the textured wall column stepper.
// ----------------------------------------------------------------------------
package twcs_pkg;

    localparam int COL_W      = 12;
    localparam int ROW_W      = 11;
    localparam int HEIGHT_W   = 19;
    localparam int HIT_W      = 16;
    localparam int IDX_W      = 10;
    localparam int COLOR_W    = 32;
    localparam int POS_W      = 22;
    localparam int DIVIDEND_W = 30;
    localparam int DIV_CNT_W  = 5;
    localparam int TEXX_W     = 5;
    localparam int TEXY_W     = 6;
    localparam int IN_DATA_W  = 96;
    localparam int OUT_DATA_W = 56;

    localparam logic [HEIGHT_W-1:0] ONE_Q8 = HEIGHT_W'(256);

    typedef enum logic [1:0] {
        CMD_WRITE = 2'd0,
        CMD_START = 2'd1,
        CMD_NEXT  = 2'd2
    } cmd_t;

    typedef struct packed {
        logic wr_texel;
        logic load_start;
        logic div_step;
        logic mul_load;
        logic next_fetch;
        logic out_load;
    } ctrl_cmd_t;

    typedef struct packed {
        logic span_active;
        logic div_done;
        logic out_free;
    } dp_status_t;

endpackage

/* sv/textured_wall_column_stepper.sv */
// ----------------------------------------------------------------------------
// textured_wall_column_stepper
// Steps down one textured wall column of a ray-cast frame. Texels are loaded
// into a TEX_SIZE x TEX_SIZE texture store with write requests; a start
// request sets up the vertical span, centred on the screen and clamped to it,
// and the texture step; each next request emits one pixel, the final pixel of
// the span carrying tlast. A start request sets up the span, then runs the
// bit-serial step divider and then the multiply that places the first
// texture position. A next request within a span waits for the registered
// read of the texture store, and then for the output register to be free; a
// next request with no span active gives no pixel. Texels that were never
// written read back as undefined colours.
// ----------------------------------------------------------------------------
module textured_wall_column_stepper
    import twcs_pkg::*;
#(
    parameter int SCREEN_HEIGHT = 1080,
    parameter int TEX_SIZE      = 32
)
(
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  s_axis_tvalid,
    output logic                  s_axis_tready,
    // column [11:0], height [30:12], hit_pos [46:31],
    // texel_index [56:47], texel_color [88:57], zero [95:89]
    input  logic [IN_DATA_W-1:0]  s_axis_tdata,
    // command [1:0]
    input  logic [1:0]            s_axis_tuser,
    output logic                  m_axis_tvalid,
    input  logic                  m_axis_tready,
    // pixel_column [11:0], pixel_row [22:12], pixel_color [54:23], zero [55]
    output logic [OUT_DATA_W-1:0] m_axis_tdata,
    // last_pixel
    output logic                  m_axis_tlast
);

    ctrl_cmd_t          ctrl_cmd;
    dp_status_t         dp_status;
    logic [COL_W-1:0]   pix_column;
    logic [ROW_W-1:0]   pix_row;
    logic [COLOR_W-1:0] pix_color;
    logic               in_accept;

    assign in_accept = s_axis_tvalid && s_axis_tready;

    twcs_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (s_axis_tvalid),
        .in_cmd   (s_axis_tuser),
        .in_ready (s_axis_tready),
        .status   (dp_status),
        .cmd      (ctrl_cmd)
    );

    twcs_datapath #(
        .SCREEN_HEIGHT (SCREEN_HEIGHT),
        .TEX_SIZE      (TEX_SIZE)
    ) u_datapath (
        .clk        (clk),
        .rst_n      (rst_n),
        .cmd        (ctrl_cmd),
        .status     (dp_status),
        .in_column  (s_axis_tdata[11:0]),
        .in_height  (s_axis_tdata[30:12]),
        .in_hit     (s_axis_tdata[46:31]),
        .in_index   (s_axis_tdata[56:47]),
        .in_color   (s_axis_tdata[88:57]),
        .out_valid  (m_axis_tvalid),
        .out_ready  (m_axis_tready),
        .out_column (pix_column),
        .out_row    (pix_row),
        .out_color  (pix_color),
        .out_last   (m_axis_tlast)
    );

    assign m_axis_tdata = {1'b0, pix_color, pix_row, pix_column};

`ifndef ASSERT_OFF
    a_start_busy: assert property (@(posedge clk) disable iff (!rst_n)
        (in_accept && (s_axis_tuser == CMD_START)) |=> !s_axis_tready)
        else $error("start request did not hold off further requests");

    a_fetch_busy: assert property (@(posedge clk) disable iff (!rst_n)
        (in_accept && (s_axis_tuser == CMD_NEXT) && dp_status.span_active)
        |=> !s_axis_tready)
        else $error("pixel request did not wait for the texture read");

    a_out_free: assert property (@(posedge clk) disable iff (!rst_n)
        ctrl_cmd.out_load |-> (!m_axis_tvalid || m_axis_tready))
        else $error("output register overwritten while a pixel was waiting");

    a_cmd_excl: assert property (@(posedge clk) disable iff (!rst_n)
        $onehot0({ctrl_cmd.load_start, ctrl_cmd.div_step, ctrl_cmd.mul_load,
                  ctrl_cmd.next_fetch, ctrl_cmd.out_load}))
        else $error("conflicting datapath commands");
`endif

endmodule

/* sv/twcs_ctrl.sv */
// ----------------------------------------------------------------------------
// twcs_ctrl
// Sequencer: accepts requests, runs the step division and the start multiply,
// and waits for the texture read before handing a pixel to the output.
// ----------------------------------------------------------------------------
module twcs_ctrl
    import twcs_pkg::*;
(
    input  logic       clk,
    input  logic       rst_n,
    input  logic       in_valid,
    input  logic [1:0] in_cmd,
    output logic       in_ready,
    input  dp_status_t status,
    output ctrl_cmd_t  cmd
);

    typedef enum logic [3:0] {
        ST_IDLE  = 4'b0001,
        ST_DIV   = 4'b0010,
        ST_MUL   = 4'b0100,
        ST_FETCH = 4'b1000
    } state_t;

    state_t state_reg;
    state_t state_next;
    logic   accept;

    assign in_ready = (state_reg == ST_IDLE);
    assign accept   = in_valid && in_ready;

    always_comb
    begin
        state_next = state_reg;
        cmd        = '0;
        unique case (state_reg)
            ST_IDLE:
            begin
                if (accept)
                begin
                    unique case (in_cmd)
                        CMD_WRITE:
                        begin
                            cmd.wr_texel = 1'b1;
                        end
                        CMD_START:
                        begin
                            cmd.load_start = 1'b1;
                            state_next     = ST_DIV;
                        end
                        CMD_NEXT:
                        begin
                            if (status.span_active)
                            begin
                                cmd.next_fetch = 1'b1;
                                state_next     = ST_FETCH;
                            end
                        end
                        default:
                        begin
                            state_next = ST_IDLE;
                        end
                    endcase
                end
            end
            ST_DIV:
            begin
                cmd.div_step = 1'b1;
                if (status.div_done)
                begin
                    state_next = ST_MUL;
                end
            end
            ST_MUL:
            begin
                cmd.mul_load = 1'b1;
                state_next   = ST_IDLE;
            end
            ST_FETCH:
            begin
                if (status.out_free)
                begin
                    cmd.out_load = 1'b1;
                    state_next   = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

endmodule

/* sv/twcs_datapath.sv */
// ----------------------------------------------------------------------------
// twcs_datapath
// Span set-up, bit-serial step divider, start multiply, texture position
// stepping, texture store and output register.
// ----------------------------------------------------------------------------
module twcs_datapath
    import twcs_pkg::*;
#(
    parameter int SCREEN_HEIGHT = 1080,
    parameter int TEX_SIZE      = 32
)
(
    input  logic                clk,
    input  logic                rst_n,
    input  ctrl_cmd_t           cmd,
    output dp_status_t          status,
    input  logic [COL_W-1:0]    in_column,
    input  logic [HEIGHT_W-1:0] in_height,
    input  logic [HIT_W-1:0]    in_hit,
    input  logic [IDX_W-1:0]    in_index,
    input  logic [COLOR_W-1:0]  in_color,
    output logic                out_valid,
    input  logic                out_ready,
    output logic [COL_W-1:0]    out_column,
    output logic [ROW_W-1:0]    out_row,
    output logic [COLOR_W-1:0]  out_color,
    output logic                out_last
);

    localparam logic [ROW_W-1:0]      MID      = ROW_W'(SCREEN_HEIGHT / 2);
    localparam logic [ROW_W-1:0]      SCR_H    = ROW_W'(SCREEN_HEIGHT);
    localparam logic [TEXY_W-1:0]     TEX_W    = TEXY_W'(TEX_SIZE);
    localparam logic [TEXY_W-1:0]     TEX_MASK = TEXY_W'(TEX_SIZE - 1);
    localparam logic [DIVIDEND_W-1:0] DIVIDEND = DIVIDEND_W'(TEX_SIZE) << 24;
    localparam logic [DIV_CNT_W-1:0]  CNT_TOP  = DIV_CNT_W'(DIVIDEND_W - 1);

    // Span set-up from the start request
    logic [HEIGHT_W-1:0]        h_sat;
    logic [9:0]                 half;
    logic [ROW_W-1:0]           first_row;
    logic [ROW_W-1:0]           mid_sum;
    logic [ROW_W-1:0]           last_end;
    logic [ROW_W-1:0]           mid_diff;
    logic [HEIGHT_W-1:0]        offset_calc;
    logic [HIT_W+TEXY_W-1:0]    hit_prod;

    // Division and start multiply
    logic [HEIGHT_W:0]          rem_shift;
    logic                       q_bit;
    logic [HEIGHT_W+POS_W-1:0]  pos_prod;

    // Stepping
    logic [POS_W-1:0]           pos_step;
    logic [TEXY_W-1:0]          tex_y;
    logic [2*TEXY_W-1:0]        addr_wide;
    logic [IDX_W-1:0]           rd_addr;
    logic [ROW_W-1:0]           row_inc;
    logic                       is_last;

    logic [POS_W-1:0]           step_reg,   step_next;
    logic [POS_W-1:0]           pos_reg,    pos_next;
    logic [ROW_W-1:0]           row_reg,    row_next;
    logic [ROW_W-1:0]           end_reg,    end_next;
    logic [COL_W-1:0]           col_reg,    col_next;
    logic [TEXX_W-1:0]          texx_reg,   texx_next;
    logic                       active_reg, active_next;
    logic [DIV_CNT_W-1:0]       cnt_reg,    cnt_next;
    logic                       ovalid_reg, ovalid_next;

    logic [HEIGHT_W-1:0]        h_reg;
    logic [HEIGHT_W-1:0]        offset_reg;
    logic [HEIGHT_W-1:0]        rem_reg;
    logic [ROW_W-1:0]           prow_reg;
    logic                       plast_reg;
    logic [COLOR_W-1:0]         rd_data_reg;
    logic [COL_W-1:0]           ocol_reg;
    logic [ROW_W-1:0]           orow_reg;
    logic [COLOR_W-1:0]         ocolor_reg;
    logic                       olast_reg;

    logic [COLOR_W-1:0]         tex_mem [2**IDX_W];

    always_comb
    begin
        h_sat       = (in_height < ONE_Q8) ? ONE_Q8 : in_height;
        half        = h_sat[HEIGHT_W-1:9];
        first_row   = ({1'b0, half} > MID) ? '0 : MID - {1'b0, half};
        mid_sum     = MID + {1'b0, half};
        last_end    = (mid_sum > SCR_H) ? SCR_H : mid_sum;
        mid_diff    = MID - first_row;
        offset_calc = h_sat - {mid_diff[9:0], 9'b0};
        hit_prod    = {{TEXY_W{1'b0}}, in_hit} * {{HIT_W{1'b0}}, TEX_W};
    end

    always_comb
    begin
        rem_shift = {rem_reg, DIVIDEND[cnt_reg]};
        q_bit     = (rem_shift >= {1'b0, h_reg});
        pos_prod  = {{POS_W{1'b0}}, offset_reg} * {{HEIGHT_W{1'b0}}, step_reg};
    end

    always_comb
    begin
        pos_step  = pos_reg + step_reg;
        tex_y     = pos_step[POS_W-1:16] & TEX_MASK;
        addr_wide = (tex_y * TEX_W) + {{(2*TEXY_W-TEXX_W){1'b0}}, texx_reg};
        rd_addr   = addr_wide[IDX_W-1:0];
        row_inc   = row_reg + ROW_W'(1);
        is_last   = (row_inc >= end_reg);
    end

    always_comb
    begin
        step_next   = step_reg;
        pos_next    = pos_reg;
        row_next    = row_reg;
        end_next    = end_reg;
        col_next    = col_reg;
        texx_next   = texx_reg;
        active_next = active_reg;
        cnt_next    = cnt_reg;
        ovalid_next = ovalid_reg;

        if (cmd.load_start)
        begin
            step_next   = '0;
            cnt_next    = CNT_TOP;
            row_next    = first_row;
            end_next    = last_end;
            col_next    = in_column;
            texx_next   = hit_prod[HIT_W+TEXX_W-1:HIT_W];
            active_next = (first_row < last_end);
        end
        if (cmd.div_step)
        begin
            step_next = {step_reg[POS_W-2:0], q_bit};
            cnt_next  = cnt_reg - DIV_CNT_W'(1);
        end
        if (cmd.mul_load)
        begin
            pos_next = pos_prod[POS_W+8:9];
        end
        if (cmd.next_fetch)
        begin
            pos_next = pos_step;
            row_next = row_inc;
            if (is_last)
            begin
                active_next = 1'b0;
            end
        end
        if (cmd.out_load)
        begin
            ovalid_next = 1'b1;
        end
        else if (out_ready)
        begin
            ovalid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            step_reg   <= '0;
            pos_reg    <= '0;
            row_reg    <= '0;
            end_reg    <= '0;
            col_reg    <= '0;
            texx_reg   <= '0;
            active_reg <= 1'b0;
            cnt_reg    <= '0;
            ovalid_reg <= 1'b0;
        end
        else
        begin
            step_reg   <= step_next;
            pos_reg    <= pos_next;
            row_reg    <= row_next;
            end_reg    <= end_next;
            col_reg    <= col_next;
            texx_reg   <= texx_next;
            active_reg <= active_next;
            cnt_reg    <= cnt_next;
            ovalid_reg <= ovalid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.load_start)
        begin
            h_reg      <= h_sat;
            offset_reg <= offset_calc;
            rem_reg    <= '0;
        end
        else if (cmd.div_step)
        begin
            rem_reg <= q_bit ? HEIGHT_W'(rem_shift - {1'b0, h_reg})
                             : rem_shift[HEIGHT_W-1:0];
        end
        if (cmd.next_fetch)
        begin
            prow_reg  <= row_reg;
            plast_reg <= is_last;
        end
        if (cmd.out_load)
        begin
            ocol_reg   <= col_reg;
            orow_reg   <= prow_reg;
            ocolor_reg <= rd_data_reg;
            olast_reg  <= plast_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.wr_texel)
        begin
            tex_mem[in_index] <= in_color;
        end
        if (cmd.next_fetch)
        begin
            rd_data_reg <= tex_mem[rd_addr];
        end
    end

    assign status.span_active = active_reg;
    assign status.div_done    = (cnt_reg == '0);
    assign status.out_free    = !ovalid_reg || out_ready;

    assign out_valid  = ovalid_reg;
    assign out_column = ocol_reg;
    assign out_row    = orow_reg;
    assign out_color  = ocolor_reg;
    assign out_last   = olast_reg;

endmodule

/* dv/tb_textured_wall_column_stepper.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_textured_wall_column_stepper
// Self-checking bench for the textured wall column stepper. A short table of
// directed requests covers the field extremes, empty spans, a restart during a
// span and the unused command code. A random phase follows, made mostly of
// whole or abandoned column spans with texel writes mixed in, first among them
// one that covers the screen height. Each pixel is checked against a typed
// value or a cycle-free predictor. Both stream sides idle and stall at random.
// ----------------------------------------------------------------------------
module tb_textured_wall_column_stepper
    import twcs_pkg::*;
();

    localparam int SCREEN_HEIGHT = 1080;
    localparam int TEX_SIZE      = 32;
    localparam int MID_ROW       = SCREEN_HEIGHT / 2;
    localparam int STORE_DEPTH   = 1024;
    localparam int RANDOM_ITEMS  = 800;
    localparam int CYCLE_LIMIT   = 1_000_000;
    localparam int DRAIN_LIMIT   = 20_000;
    localparam int SETTLE_CYCLES = 40;

    localparam logic [1:0] CMD_UNUSED = 2'd3;

    typedef struct packed {
        logic [1:0]          cmd;
        logic [COL_W-1:0]    column;
        logic [HEIGHT_W-1:0] height;
        logic [HIT_W-1:0]    hit;
        logic [IDX_W-1:0]    idx;
        logic [COLOR_W-1:0]  color;
    } req_t;

    typedef struct packed {
        logic [COL_W-1:0]   column;
        logic [ROW_W-1:0]   row;
        logic [COLOR_W-1:0] color;
        logic               last;
    } pixel_t;

    typedef enum logic [1:0] {
        KIND_PREDICT,
        KIND_TYPED,
        KIND_SILENT
    } check_kind_t;

    typedef struct packed {
        req_t        rq;
        check_kind_t kind;
        pixel_t      want;
    } stim_row_t;

    localparam pixel_t NO_PIXEL = '0;
    localparam int DIR_ROWS = 26;

    // Extremes, empty spans and a restart during a span; the two typed pixels
    // come from a 2.0 high wall whose step is exactly 16 texture rows.
    localparam stim_row_t DIRECTED [DIR_ROWS] = '{
        '{'{CMD_NEXT,   12'h000, 19'h00000, 16'h0000, 10'h000, 32'h0000_0000},
          KIND_SILENT, NO_PIXEL},
        '{'{CMD_UNUSED, 12'hFFF, 19'h7FFFF, 16'hFFFF, 10'h3FF, 32'hFFFF_FFFF},
          KIND_SILENT, NO_PIXEL},
        '{'{CMD_WRITE,  12'h000, 19'h00000, 16'h0000, 10'h000, 32'h1111_0000},
          KIND_PREDICT, NO_PIXEL},
        '{'{CMD_WRITE,  12'h000, 19'h00000, 16'h0000, 10'h200, 32'h2222_0200},
          KIND_PREDICT, NO_PIXEL},
        '{'{CMD_WRITE,  12'hFFF, 19'h7FFFF, 16'hFFFF, 10'h3FF, 32'hFFFF_FFFF},
          KIND_PREDICT, NO_PIXEL},
        '{'{CMD_WRITE,  12'h000, 19'h00000, 16'h0000, 10'h001, 32'h0000_0000},
          KIND_PREDICT, NO_PIXEL},
        '{'{CMD_START,  12'h000, 19'h00000, 16'h0000, 10'h000, 32'h0000_0000},
          KIND_PREDICT, NO_PIXEL},
        '{'{CMD_NEXT,   12'h000, 19'h00000, 16'h0000, 10'h000, 32'h0000_0000},
          KIND_SILENT, NO_PIXEL},
        '{'{CMD_START,  12'h005, 19'h001FF, 16'hFFFF, 10'h000, 32'h0000_0000},
          KIND_PREDICT, NO_PIXEL},
        '{'{CMD_NEXT,   12'h000, 19'h00000, 16'h0000, 10'h000, 32'h0000_0000},
          KIND_SILENT, NO_PIXEL},
        '{'{CMD_START,  12'hFFF, 19'h00200, 16'h0000, 10'h000, 32'h0000_0000},
          KIND_PREDICT, NO_PIXEL},
        '{'{CMD_NEXT,   12'h000, 19'h00000, 16'h0000, 10'h000, 32'h0000_0000},
          KIND_TYPED, '{12'hFFF, 11'd539, 32'h2222_0200, 1'b0}},
        '{'{CMD_NEXT,   12'h000, 19'h00000, 16'h0000, 10'h000, 32'h0000_0000},
          KIND_TYPED, '{12'hFFF, 11'd540, 32'h1111_0000, 1'b1}},
        '{'{CMD_NEXT,   12'h000, 19'h00000, 16'h0000, 10'h000, 32'h0000_0000},
          KIND_SILENT, NO_PIXEL},
        '{'{CMD_START,  12'h007, 19'h7FFFF, 16'hFFFF, 10'h000, 32'h0000_0000},
          KIND_PREDICT, NO_PIXEL},
        '{'{CMD_NEXT,   12'hFFF, 19'h7FFFF, 16'hFFFF, 10'h3FF, 32'hFFFF_FFFF},
          KIND_PREDICT, NO_PIXEL},
        '{'{CMD_UNUSED, 12'h000, 19'h00000, 16'h0000, 10'h000, 32'h0000_0000},
          KIND_SILENT, NO_PIXEL},
        '{'{CMD_NEXT,   12'h000, 19'h00000, 16'h0000, 10'h000, 32'h0000_0000},
          KIND_PREDICT, NO_PIXEL},
        '{'{CMD_START,  12'h064, 19'h04000, 16'h8000, 10'h000, 32'h0000_0000},
          KIND_PREDICT, NO_PIXEL},
        '{'{CMD_WRITE,  12'h000, 19'h00000, 16'h0000, 10'h010, 32'hA5A5_5A5A},
          KIND_PREDICT, NO_PIXEL},
        '{'{CMD_NEXT,   12'h000, 19'h00000, 16'h0000, 10'h000, 32'h0000_0000},
          KIND_PREDICT, NO_PIXEL},
        '{'{CMD_NEXT,   12'h000, 19'h00000, 16'h0000, 10'h000, 32'h0000_0000},
          KIND_PREDICT, NO_PIXEL},
        '{'{CMD_WRITE,  12'h000, 19'h00000, 16'h0000, 10'h030, 32'h5A5A_A5A5},
          KIND_PREDICT, NO_PIXEL},
        '{'{CMD_NEXT,   12'h000, 19'h00000, 16'h0000, 10'h000, 32'h0000_0000},
          KIND_PREDICT, NO_PIXEL},
        '{'{CMD_START,  12'h800, 19'h00100, 16'h4000, 10'h000, 32'h0000_0000},
          KIND_PREDICT, NO_PIXEL},
        '{'{CMD_NEXT,   12'h000, 19'h00000, 16'h0000, 10'h000, 32'h0000_0000},
          KIND_SILENT, NO_PIXEL}
    };

    logic                  clk;
    logic                  rst_n;
    logic                  s_axis_tvalid;
    logic                  s_axis_tready;
    logic [IN_DATA_W-1:0]  s_axis_tdata;
    logic [1:0]            s_axis_tuser;
    logic                  m_axis_tvalid;
    logic                  m_axis_tready;
    logic [OUT_DATA_W-1:0] m_axis_tdata;
    logic                  m_axis_tlast;

    logic [COLOR_W-1:0]  tex_mem [STORE_DEPTH];
    bit                  tex_written [STORE_DEPTH];
    logic [POS_W-1:0]    step_q;
    logic [POS_W-1:0]    pos_q;
    logic [ROW_W-1:0]    row_q;
    logic [ROW_W-1:0]    end_q;
    logic [COL_W-1:0]    col_q;
    logic [TEXX_W-1:0]   texx_q;
    bit                  span_on;

    pixel_t pending_pixels [$];
    bit     calm = 1'b0;
    int     error_count = 0;
    int     items_sent = 0;
    int     starts_seen = 0;
    int     empty_spans = 0;
    int     pixels_checked = 0;
    int     cycle_count = 0;

    textured_wall_column_stepper #(
        .SCREEN_HEIGHT(SCREEN_HEIGHT),
        .TEX_SIZE     (TEX_SIZE)
    ) u_top (
        .clk          (clk),
        .rst_n        (rst_n),
        .s_axis_tvalid(s_axis_tvalid),
        .s_axis_tready(s_axis_tready),
        .s_axis_tdata (s_axis_tdata),
        .s_axis_tuser (s_axis_tuser),
        .m_axis_tvalid(m_axis_tvalid),
        .m_axis_tready(m_axis_tready),
        .m_axis_tdata (m_axis_tdata),
        .m_axis_tlast (m_axis_tlast)
    );

    initial
    begin
        clk = 1'b0;
        forever #6 clk = ~clk;
    end

    function automatic req_t random_request();
        req_t rq;
        rq.cmd    = 2'($urandom_range(0, 3));
        rq.column = COL_W'($urandom());
        rq.height = HEIGHT_W'($urandom());
        rq.hit    = HIT_W'($urandom());
        rq.idx    = IDX_W'($urandom());
        rq.color  = $urandom();
        return rq;
    endfunction

    function automatic logic [IDX_W-1:0] upcoming_addr();
        logic [POS_W-1:0] p;
        p = pos_q + step_q;
        return IDX_W'(((p >> 16) & (TEX_SIZE - 1)) * TEX_SIZE + texx_q);
    endfunction

    task automatic apply_request(input req_t rq, output bit has_px, output pixel_t px);
        logic [HEIGHT_W-1:0] h;
        int unsigned         half;
        int unsigned         first;
        int unsigned         last_end;
        int unsigned         off_q9;
        logic [63:0]         prod;
        logic [IDX_W-1:0]    addr;
        has_px = 1'b0;
        px     = NO_PIXEL;
        case (rq.cmd)
            CMD_WRITE:
            begin
                tex_mem[rq.idx]     = rq.color;
                tex_written[rq.idx] = 1'b1;
            end
            CMD_START:
            begin
                h = (rq.height < ONE_Q8) ? ONE_Q8 : rq.height;
                half     = h >> 9;
                first    = (half > MID_ROW) ? 0 : MID_ROW - half;
                last_end = MID_ROW + half;
                if (last_end > SCREEN_HEIGHT)
                    last_end = SCREEN_HEIGHT;
                step_q  = POS_W'((64'(TEX_SIZE) << 24) / 64'(h));
                off_q9  = h - ((MID_ROW - first) << 9);
                prod    = 64'(off_q9) * 64'(step_q);
                pos_q   = POS_W'(prod >> 9);
                col_q   = rq.column;
                texx_q  = TEXX_W'((32'(rq.hit) * TEX_SIZE) >> 16);
                row_q   = ROW_W'(first);
                end_q   = ROW_W'(last_end);
                span_on = first < last_end;
                starts_seen++;
                if (!span_on)
                    empty_spans++;
            end
            CMD_NEXT:
            begin
                if (span_on)
                begin
                    addr      = upcoming_addr();
                    pos_q     = pos_q + step_q;
                    px.column = col_q;
                    px.row    = row_q;
                    px.color  = tex_mem[addr];
                    px.last   = ROW_W'(row_q + 1) >= end_q;
                    has_px    = 1'b1;
                    row_q     = row_q + 1'b1;
                    if (px.last)
                        span_on = 1'b0;
                end
            end
            default:
            begin
            end
        endcase
    endtask

    // Called at a falling edge; returns at the falling edge after acceptance.
    task automatic send_request(input req_t rq, input check_kind_t kind,
                                input pixel_t typed);
        int     gap;
        bit     has_px;
        pixel_t px;
        gap = 0;
        if (!calm)
        begin
            case ($urandom_range(0, 9))
                0, 1, 2, 3, 4: gap = 0;
                5, 6, 7, 8:    gap = $urandom_range(1, 3);
                default:       gap = $urandom_range(8, 30);
            endcase
        end
        if (gap > 0)
        begin
            s_axis_tvalid = 1'b0;
            repeat (gap) @(negedge clk);
        end
        s_axis_tdata  = IN_DATA_W'({rq.color, rq.idx, rq.hit, rq.height, rq.column});
        s_axis_tuser  = rq.cmd;
        s_axis_tvalid = 1'b1;
        @(posedge clk);
        while (!s_axis_tready)
            @(posedge clk);
        apply_request(rq, has_px, px);
        items_sent++;
        if (kind == KIND_TYPED)
            pending_pixels.push_back(typed);
        else if (kind == KIND_PREDICT && has_px)
            pending_pixels.push_back(px);
        @(negedge clk);
    endtask

    // A next request within a span never reads a texel that was not written.
    task automatic issue(input req_t rq, input check_kind_t kind, input pixel_t typed);
        req_t fill;
        if (rq.cmd == CMD_NEXT && span_on && !tex_written[upcoming_addr()])
        begin
            fill      = random_request();
            fill.cmd  = CMD_WRITE;
            fill.idx  = upcoming_addr();
            send_request(fill, KIND_PREDICT, NO_PIXEL);
        end
        send_request(rq, kind, typed);
    endtask

    task automatic run_span(input logic [HEIGHT_W-1:0] h, input bit whole);
        req_t rq;
        int   limit;
        int   n;
        int   span_len;
        rq        = random_request();
        rq.cmd    = CMD_START;
        rq.height = h;
        issue(rq, KIND_PREDICT, NO_PIXEL);
        span_len = span_on ? int'(end_q) - int'(row_q) : 0;
        if (whole)
            limit = SCREEN_HEIGHT;
        else if (span_len > 64)
            limit = $urandom_range(1, 24);
        else if (span_len > 0 && $urandom_range(0, 99) < 15)
            limit = $urandom_range(0, span_len - 1);
        else
            limit = span_len;
        n = 0;
        while (span_on && n < limit)
        begin
            case ($urandom_range(0, 24))
                0, 1:
                begin
                    rq     = random_request();
                    rq.cmd = CMD_WRITE;
                    issue(rq, KIND_PREDICT, NO_PIXEL);
                end
                2:
                begin
                    rq     = random_request();
                    rq.cmd = CMD_UNUSED;
                    issue(rq, KIND_PREDICT, NO_PIXEL);
                end
                default:
                begin
                end
            endcase
            rq     = random_request();
            rq.cmd = CMD_NEXT;
            issue(rq, KIND_PREDICT, NO_PIXEL);
            n++;
        end
        if (!span_on && $urandom_range(0, 3) == 0)
        begin
            rq     = random_request();
            rq.cmd = CMD_NEXT;
            issue(rq, KIND_PREDICT, NO_PIXEL);
        end
    endtask

    initial
    begin : pacing_mode
        forever
        begin
            repeat ($urandom_range(100, 400)) @(posedge clk);
            calm = !calm;
        end
    end

    initial
    begin : sink_pacing
        int hold;
        hold = 0;
        m_axis_tready = 1'b0;
        forever
        begin
            @(negedge clk);
            if (calm)
                m_axis_tready = 1'b1;
            else if (hold > 0)
                hold--;
            else
            begin
                m_axis_tready = ($urandom_range(0, 2) != 0);
                hold = ($urandom_range(0, 9) == 0) ? $urandom_range(8, 40)
                                                   : $urandom_range(0, 3);
            end
        end
    end

    always @(posedge clk)
    begin : check_pixels
        pixel_t want;
        if (rst_n && m_axis_tvalid && m_axis_tready)
        begin
            if (pending_pixels.size() == 0)
            begin
                $error("Unexpected pixel: column %0d, row %0d.",
                       m_axis_tdata[11:0], m_axis_tdata[22:12]);
                error_count++;
            end
            else
            begin
                want = pending_pixels.pop_front();
                pixels_checked++;
                if (m_axis_tdata[11:0] !== want.column)
                begin
                    $error("pixel_column: expected %0d, got %0d", want.column,
                           m_axis_tdata[11:0]);
                    error_count++;
                end
                if (m_axis_tdata[22:12] !== want.row)
                begin
                    $error("pixel_row: expected %0d, got %0d", want.row,
                           m_axis_tdata[22:12]);
                    error_count++;
                end
                if (m_axis_tdata[54:23] !== want.color)
                begin
                    $error("pixel_color: expected %h, got %h", want.color,
                           m_axis_tdata[54:23]);
                    error_count++;
                end
                if (m_axis_tlast !== want.last)
                begin
                    $error("last_pixel: expected %0d, got %0d", want.last, m_axis_tlast);
                    error_count++;
                end
            end
        end
    end

    initial
    begin : watchdog
        while (cycle_count < CYCLE_LIMIT)
        begin
            @(posedge clk);
            cycle_count++;
        end
        $error("Run stopped after %0d cycles without finishing.", cycle_count);
        $display("** textured_wall_column_stepper: FAILED **");
        $finish;
    end

    initial
    begin : stimulus
        req_t rq;
        int   target;
        int   drain;
        int   k;
        rst_n         = 1'b0;
        s_axis_tvalid = 1'b0;
        s_axis_tdata  = '0;
        s_axis_tuser  = CMD_WRITE;
        step_q        = '0;
        pos_q         = '0;
        row_q         = '0;
        end_q         = '0;
        col_q         = '0;
        texx_q        = '0;
        span_on       = 1'b0;
        foreach (tex_written[i])
            tex_written[i] = 1'b0;
        repeat (11) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        foreach (DIRECTED[i])
            issue(DIRECTED[i].rq, DIRECTED[i].kind, DIRECTED[i].want);

        target = items_sent + RANDOM_ITEMS;
        run_span(HEIGHT_W'($urandom_range(SCREEN_HEIGHT * 256, 19'h7FFFF)), 1'b0);
        while (items_sent < target)
        begin
            case ($urandom_range(0, 19))
                0, 1, 2:
                begin
                    for (k = $urandom_range(1, 8); k > 0; k--)
                    begin
                        rq     = random_request();
                        rq.cmd = CMD_WRITE;
                        issue(rq, KIND_PREDICT, NO_PIXEL);
                    end
                end
                3, 4:
                    run_span(HEIGHT_W'($urandom_range(0, 511)), 1'b0);
                5, 6:
                begin
                    for (k = $urandom_range(1, 6); k > 0; k--)
                        issue(random_request(), KIND_PREDICT, NO_PIXEL);
                end
                7, 8:
                    run_span(HEIGHT_W'($urandom()), 1'b0);
                default:
                    run_span(HEIGHT_W'($urandom_range(512, 48 * 256)), 1'b0);
            endcase
        end
        s_axis_tvalid = 1'b0;

        drain = 0;
        while (pending_pixels.size() != 0 && drain < DRAIN_LIMIT)
        begin
            @(posedge clk);
            drain++;
        end
        repeat (SETTLE_CYCLES) @(posedge clk);
        if (pending_pixels.size() != 0)
        begin
            $error("%0d expected pixels never arrived.", pending_pixels.size());
            error_count++;
        end

        $display("Sent %0d requests, among them %0d column starts (%0d with no rows).",
                 items_sent, starts_seen, empty_spans);
        $display("Checked %0d pixels in %0d cycles, %0d mismatches.",
                 pixels_checked, cycle_count, error_count);
        if (error_count == 0)
            $display("** textured_wall_column_stepper: PASSED **");
        else
            $display("** textured_wall_column_stepper: FAILED **");
        $finish;
    end

endmodule

/* sim.f */
sv/twcs_pkg.sv
sv/twcs_ctrl.sv
sv/twcs_datapath.sv
sv/textured_wall_column_stepper.sv
dv/tb_textured_wall_column_stepper.sv
